>>> rtl/ltr_pkg.sv
package ltr_pkg;

  localparam int DEF_COUNT_BITS = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [31:0] DJB_SEED = 32'd5381;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_TOKEN = 3'b010,
    PH_SKIP  = 3'b100
  } phase_t;

  typedef struct packed {
    logic is_lf;
    logic is_cr;
    logic skip_lead;
    logic is_delim;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] pos;
    byte_class_t cls;
  } item_t;

endpackage

>>> rtl/ltr_front.sv
module ltr_front #(
  parameter int COUNT_BITS = ltr_pkg::DEF_COUNT_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  output logic            push,
  input  logic            q_ready,
  output ltr_pkg::item_t  push_item
);

  logic [COUNT_BITS-1:0] pos_r;
  logic [COUNT_BITS-1:0] pos_nxt;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;
  assign pos_nxt  = pos_r + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (push) begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    push_item.data          = in_data_byte;
    push_item.pos           = 32'(pos_r);
    push_item.cls.is_lf     = (in_data_byte == ltr_pkg::CH_LF);
    push_item.cls.is_cr     = (in_data_byte == ltr_pkg::CH_CR);
    push_item.cls.skip_lead = (in_data_byte == ltr_pkg::CH_HASH)
                           || (in_data_byte == ltr_pkg::CH_LBRACE)
                           || (in_data_byte == ltr_pkg::CH_RBRACE)
                           || (in_data_byte == ltr_pkg::CH_TAB);
    push_item.cls.is_delim  = (in_data_byte == ltr_pkg::CH_TAB)
                           || (in_data_byte == ltr_pkg::CH_SPACE)
                           || (in_data_byte == ltr_pkg::CH_NUL);
  end

endmodule

>>> rtl/ltr_queue.sv
module ltr_queue #(
  parameter int DEPTH = ltr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ltr_pkg::item_t  push_item,
  output logic            q_ready,
  output logic            q_valid,
  input  logic            pop,
  output ltr_pkg::item_t  pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ltr_pkg::item_t slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;

  assign q_ready  = (count_r != CW'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // pointers wrap at the depth, which need not be a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/ltr_back.sv
module ltr_back #(
  parameter int COUNT_BITS = ltr_pkg::DEF_COUNT_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            pop,
  input  ltr_pkg::item_t  pop_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_line_number,
  output logic [31:0]     out_token_offset,
  output logic [31:0]     out_sum_hash,
  output logic [31:0]     out_djb2_hash
);

  logic [COUNT_BITS-1:0] line_r, line_nxt;
  logic [31:0]           start_r, start_nxt;
  ltr_pkg::phase_t       phase_r, phase_nxt;
  logic                  pending_r, pending_nxt;
  logic                  after_cr_r, after_cr_nxt;
  logic [15:0]           sum_r, sum_nxt;
  logic [15:0]           len_r, len_nxt;
  logic [31:0]           djb_r, djb_nxt;
  logic                  emit;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           line_out_r, offset_out_r, sum_out_r, djb_out_r;

  logic [15:0] sum_add;
  logic [15:0] len_add;
  logic [31:0] djb_add;

  assign pop = q_valid && (!out_valid_r || out_ready);

  assign sum_add = sum_r + {8'd0, pop_item.data};
  assign len_add = len_r + 16'd1;
  // h*33 + b as shift and add
  assign djb_add = {djb_r[26:0], 5'd0} + djb_r + {24'd0, pop_item.data};

  always_comb begin
    line_nxt     = line_r;
    start_nxt    = start_r;
    phase_nxt    = phase_r;
    pending_nxt  = pending_r;
    after_cr_nxt = after_cr_r;
    sum_nxt      = sum_r;
    len_nxt      = len_r;
    djb_nxt      = djb_r;
    emit         = 1'b0;
    if (pop) begin
      if (pop_item.cls.is_lf && after_cr_r) begin
        // lf that completes a cr lf pair
        after_cr_nxt = 1'b0;
      end else begin
        after_cr_nxt = pop_item.cls.is_cr;
        if (pop_item.cls.is_lf || pop_item.cls.is_cr) begin
          line_nxt    = line_r + COUNT_BITS'(1);
          emit        = pending_r;
          pending_nxt = 1'b0;
          sum_nxt     = '0;
          len_nxt     = '0;
          djb_nxt     = ltr_pkg::DJB_SEED;
          phase_nxt   = ltr_pkg::PH_START;
        end else begin
          case (phase_r)
            ltr_pkg::PH_START: begin
              if (pop_item.cls.skip_lead) begin
                phase_nxt = ltr_pkg::PH_SKIP;
              end else begin
                start_nxt   = pop_item.pos;
                pending_nxt = 1'b1;
                sum_nxt     = sum_add;
                len_nxt     = len_add;
                djb_nxt     = djb_add;
                phase_nxt   = ltr_pkg::PH_TOKEN;
              end
            end
            ltr_pkg::PH_TOKEN: begin
              if (pop_item.cls.is_delim) begin
                phase_nxt = ltr_pkg::PH_SKIP;
              end else begin
                sum_nxt = sum_add;
                len_nxt = len_add;
                djb_nxt = djb_add;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= '0;
      start_r     <= '0;
      phase_r     <= ltr_pkg::PH_START;
      pending_r   <= 1'b0;
      after_cr_r  <= 1'b0;
      sum_r       <= '0;
      len_r       <= '0;
      djb_r       <= ltr_pkg::DJB_SEED;
      out_valid_r <= 1'b0;
    end else begin
      line_r      <= line_nxt;
      start_r     <= start_nxt;
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      after_cr_r  <= after_cr_nxt;
      sum_r       <= sum_nxt;
      len_r       <= len_nxt;
      djb_r       <= djb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      line_out_r   <= 32'(line_nxt);
      offset_out_r <= start_r;
      sum_out_r    <= {len_r, sum_r};
      djb_out_r    <= djb_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_number  = line_out_r;
  assign out_token_offset = offset_out_r;
  assign out_sum_hash     = sum_out_r;
  assign out_djb2_hash    = djb_out_r;

endmodule

>>> rtl/line_token_hash_records_top.sv
// a line end byte is queued, then the back registers any pending record and sets out_valid
// throughput: one byte per cycle; the front takes a byte whenever the two-entry queue has room
// the back retires one byte per cycle while the output register is free or being drained
// reset: synchronous active-low rst_n clears counters, token state and queue; hash seed 5381
module line_token_hash_records_top #(
  parameter int COUNT_BITS = ltr_pkg::DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_line_number,
  output logic [31:0] out_token_offset,
  output logic [31:0] out_sum_hash,
  output logic [31:0] out_djb2_hash
);

  logic           push;
  logic           q_ready;
  logic           q_valid;
  logic           pop;
  ltr_pkg::item_t push_item;
  ltr_pkg::item_t pop_item;

  ltr_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .push         (push),
    .q_ready      (q_ready),
    .push_item    (push_item)
  );

  ltr_queue #(
    .DEPTH(ltr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .q_valid   (q_valid),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  ltr_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .pop              (pop),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_number  (out_line_number),
    .out_token_offset (out_token_offset),
    .out_sum_hash     (out_sum_hash),
    .out_djb2_hash    (out_djb2_hash)
  );

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_TOKEN_BYTES = 300;

  typedef struct {
    logic [31:0] line_number;
    logic [31:0] token_offset;
    logic [31:0] sum_hash;
    logic [31:0] djb2_hash;
  } line_record_t;

  // tracks line and token state and holds the records still owed by the block
  class line_record_board;
    logic [31:0]      line_cnt;
    logic [31:0]      byte_pos;
    logic [31:0]      tok_start;
    ltr_pkg::phase_t  line_phase;
    bit               tok_open;
    bit               saw_cr;
    logic [15:0]      tok_sum;
    logic [15:0]      tok_len;
    logic [31:0]      tok_djb2;
    line_record_t     pending_records[$];
    int               errors;

    function new();
      line_cnt   = '0;
      byte_pos   = '0;
      tok_start  = '0;
      line_phase = ltr_pkg::PH_START;
      saw_cr     = 1'b0;
      errors     = 0;
      clear_token();
    endfunction

    function void clear_token();
      tok_open = 1'b0;
      tok_sum  = '0;
      tok_len  = '0;
      tok_djb2 = ltr_pkg::DJB_SEED;
    endfunction

    function void add_byte(logic [7:0] b);
      tok_sum  = tok_sum + 16'(b);
      tok_len  = tok_len + 16'd1;
      tok_djb2 = tok_djb2 * 32'd33 + 32'(b);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [31:0]  pos;
      line_record_t rec;
      pos = byte_pos;
      byte_pos = byte_pos + 32'd1;
      // LF right after CR belongs to the same line end
      if (b == ltr_pkg::CH_LF && saw_cr) begin
        saw_cr = 1'b0;
        return;
      end
      saw_cr = (b == ltr_pkg::CH_CR);
      if (b == ltr_pkg::CH_LF || b == ltr_pkg::CH_CR) begin
        line_cnt = line_cnt + 32'd1;
        if (tok_open) begin
          rec.line_number  = line_cnt;
          rec.token_offset = tok_start;
          rec.sum_hash     = {tok_len, tok_sum};
          rec.djb2_hash    = tok_djb2;
          pending_records.push_back(rec);
        end
        clear_token();
        line_phase = ltr_pkg::PH_START;
        return;
      end
      case (line_phase)
        ltr_pkg::PH_START: begin
          if (b == ltr_pkg::CH_HASH || b == ltr_pkg::CH_LBRACE ||
              b == ltr_pkg::CH_RBRACE || b == ltr_pkg::CH_TAB) begin
            line_phase = ltr_pkg::PH_SKIP;
          end else begin
            tok_start  = pos;
            tok_open   = 1'b1;
            add_byte(b);
            line_phase = ltr_pkg::PH_TOKEN;
          end
        end
        ltr_pkg::PH_TOKEN: begin
          if (b == ltr_pkg::CH_TAB || b == ltr_pkg::CH_SPACE || b == ltr_pkg::CH_NUL)
            line_phase = ltr_pkg::PH_SKIP;
          else add_byte(b);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_record(line_record_t act);
      line_record_t exp_rec;
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual %h %h %h %h", $time,
                 act.line_number, act.token_offset, act.sum_hash, act.djb2_hash);
        errors++;
        return;
      end
      exp_rec = pending_records.pop_front();
      compare_field("line_number", exp_rec.line_number, act.line_number);
      compare_field("token_offset", exp_rec.token_offset, act.token_offset);
      compare_field("sum_hash", exp_rec.sum_hash, act.sum_hash);
      compare_field("djb2_hash", exp_rec.djb2_hash, act.djb2_hash);
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_line_number;
  logic [31:0] out_token_offset;
  logic [31:0] out_sum_hash;
  logic [31:0] out_djb2_hash;

  line_record_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  line_token_hash_records_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_number  (out_line_number),
    .out_token_offset (out_token_offset),
    .out_sum_hash     (out_sum_hash),
    .out_djb2_hash    (out_djb2_hash)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    line_record_t act;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        act.line_number  = out_line_number;
        act.token_offset = out_token_offset;
        act.sum_hash     = out_sum_hash;
        act.djb2_hash    = out_djb2_hash;
        board.check_record(act);
      end
      if (in_valid && in_ready) board.note_byte(in_data_byte);
    end
  end

  // valid stays high across back-to-back transfers; it only drops on an idle cycle
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_token_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ltr_pkg::CH_TAB || b == ltr_pkg::CH_SPACE || b == ltr_pkg::CH_NUL ||
           b == ltr_pkg::CH_LF || b == ltr_pkg::CH_CR);
    return b;
  endfunction

  function automatic logic [7:0] rand_line_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ltr_pkg::CH_LF || b == ltr_pkg::CH_CR);
    return b;
  endfunction

  task automatic send_line();
    int kind;
    int n;
    logic [7:0] leads[4];
    logic [7:0] delims[3];
    leads  = '{ltr_pkg::CH_HASH, ltr_pkg::CH_LBRACE, ltr_pkg::CH_RBRACE, ltr_pkg::CH_TAB};
    delims = '{ltr_pkg::CH_TAB, ltr_pkg::CH_SPACE, ltr_pkg::CH_NUL};
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // raw noise, line ends included
      n = $urandom_range(1, 8);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 22) begin
      send_byte(leads[$urandom_range(0, 3)]);
      repeat ($urandom_range(0, 5)) send_byte(rand_line_byte());
    end else if (kind >= 27) begin
      n = $urandom_range(0, 99);
      if (n < 10) send_byte(ltr_pkg::CH_SPACE);
      else if (n < 15) send_byte(ltr_pkg::CH_NUL);
      else send_byte(rand_token_byte());
      repeat ($urandom_range(0, 10)) send_byte(rand_token_byte());
      if ($urandom_range(0, 1)) begin
        send_byte(delims[$urandom_range(0, 2)]);
        repeat ($urandom_range(0, 4)) send_byte(rand_line_byte());
      end
    end
    case ($urandom_range(0, 2))
      0: send_byte(ltr_pkg::CH_LF);
      1: send_byte(ltr_pkg::CH_CR);
      default: begin
        send_byte(ltr_pkg::CH_CR);
        send_byte(ltr_pkg::CH_LF);
      end
    endcase
  endtask

  task automatic drain_records();
    while (board.pending_records.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: NUL ends a token, all-ones byte inside a token
    send_byte("a"); send_byte(8'hff); send_byte(ltr_pkg::CH_NUL); send_byte("c");
    send_byte(ltr_pkg::CH_LF);
    // NUL opening a token, CR LF counted once
    send_byte(ltr_pkg::CH_NUL); send_byte("z"); send_byte(ltr_pkg::CH_CR);
    send_byte(ltr_pkg::CH_LF);
    // leading space token ended by cr lf
    send_byte(ltr_pkg::CH_SPACE); send_byte("x"); send_byte(ltr_pkg::CH_CR);
    send_byte(ltr_pkg::CH_LF);
    // ignored lines
    send_byte(ltr_pkg::CH_HASH); send_byte("q"); send_byte(ltr_pkg::CH_LF);
    send_byte(ltr_pkg::CH_LBRACE); send_byte(ltr_pkg::CH_LF);
    send_byte(ltr_pkg::CH_RBRACE); send_byte(ltr_pkg::CH_CR);
    send_byte(ltr_pkg::CH_TAB); send_byte("k"); send_byte(ltr_pkg::CH_LF);
    // tab ends a token, CR CR gives two line ends
    send_byte("m"); send_byte(ltr_pkg::CH_TAB); send_byte(ltr_pkg::CH_CR);
    send_byte(ltr_pkg::CH_CR);

    send_idle_pct = 38;
    recv_idle_pct = 82;
    while (bytes_sent < 200) send_line();
    in_valid <= 1'b0;
    drain_records();

    send_idle_pct = 82;
    recv_idle_pct = 38;
    while (bytes_sent < 380) send_line();
    in_valid <= 1'b0;
    drain_records();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_sent < 520) send_line();
    // token long enough that the 16-bit byte sum may wrap
    send_byte(rand_token_byte());
    repeat (LONG_TOKEN_BYTES) send_byte(8'($urandom_range(128, 255)));
    send_byte(ltr_pkg::CH_CR);
    send_byte(ltr_pkg::CH_LF);
    // open token at end of stream is never reported
    send_byte("t"); send_byte("a"); send_byte("i"); send_byte("l");
    in_valid <= 1'b0;

    drain_records();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ltr_pkg.sv
rtl/ltr_front.sv
rtl/ltr_queue.sv
rtl/ltr_back.sv
rtl/line_token_hash_records_top.sv
tb/testbench.sv
